// File: src/prx_pkg.sv
// prx_pkg: shared types, sizes and codes for the pixel replicate upscaler.
// No dependencies; imported by prx_seq and pixel_replicate_upscaler.
`timescale 1ns / 1ps
`default_nettype none

package prx_pkg;

    // Sizing
    localparam int MAX_WIDTH = 1024;   // pixels per source scanline, upper bound
    localparam int MAX_SCALE = 16;     // replication count, upper bound

    localparam int ADDR_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WIDTH_W = $clog2(MAX_WIDTH + 1);
    localparam int SCALE_W = $clog2(MAX_SCALE + 1);
    localparam int REP_W   = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

    localparam int PIXEL_W = 24;

    // Register field widths are fixed by the register map
    localparam int CFG_SCALE_BITS = 5;
    localparam int CFG_WIDTH_BITS = 11;
    localparam int CFG_DATA_W     = 11;
    localparam int CFG_INDEX_W    = 1;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH = 1'b1;

    // Input operations
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PULL = 1'b1;

    // Result kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_PAD   = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_in_word;

    typedef struct packed {
        logic       kind;
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       row_end;
        logic       pass_end;
    } t_out_word;

    // Sequencer to datapath: result tags and line buffer port controls
    typedef struct packed {
        logic              res_valid;
        logic              kind;
        logic              row_end;
        logic              pass_end;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
    } t_seq_ctl;

endpackage

`default_nettype wire

// File: src/prx_ram.sv
// prx_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module prx_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                       i_wr_data,
    input  wire logic                                   i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/prx_seq.sv
// prx_seq: configuration registers and load/emit sequencer of the upscaler.
// Depends on prx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prx_seq
    import prx_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_accept,
    input  wire logic                   i_operation,
    output t_seq_ctl                    o_ctl
);

    // Effective (clamped) configuration
    logic [SCALE_W-1:0] r_scale, n_scale;
    logic [WIDTH_W-1:0] r_width, n_width;

    logic [WIDTH_W-1:0] r_load_count, n_load_count;
    logic               r_emitting, n_emitting;
    logic [WIDTH_W-1:0] r_column, n_column;
    logic [REP_W-1:0]   r_hrep, n_hrep;
    logic [REP_W-1:0]   r_vrep, n_vrep;
    logic [1:0]         r_pad_count, n_pad_count;

    logic [1:0]         pad;
    logic [WIDTH_W-1:0] load_inc;
    logic [WIDTH_W-1:0] col_inc;
    logic [REP_W:0]     hrep_inc;
    logic [REP_W:0]     vrep_inc;
    logic [2:0]         pad_inc;
    logic [CFG_SCALE_BITS-1:0] cfg_scale;
    logic [CFG_WIDTH_BITS-1:0] cfg_width;
    int unsigned        row_bytes;

    // Padding bytes per output row: only the low two bits of width and scale matter
    always_comb begin
        row_bytes = 32'd3 * 32'(r_width[1:0]) * 32'(r_scale[1:0]);
        pad       = 2'(32'd4 - (row_bytes & 32'd3));
    end

    // Configuration writes, clamped on the way in
    always_comb begin
        n_scale   = r_scale;
        n_width   = r_width;
        cfg_scale = i_cfg_data[CFG_SCALE_BITS-1:0];
        cfg_width = i_cfg_data[CFG_WIDTH_BITS-1:0];
        if (i_cfg_wr) begin
            case (i_cfg_index)
                CFG_SCALE: begin
                    if (cfg_scale == '0) begin
                        n_scale = SCALE_W'(1);
                    end else if (32'(cfg_scale) > MAX_SCALE) begin
                        n_scale = SCALE_W'(MAX_SCALE);
                    end else begin
                        n_scale = SCALE_W'(cfg_scale);
                    end
                end
                CFG_WIDTH: begin
                    if (cfg_width == '0) begin
                        n_width = WIDTH_W'(1);
                    end else if (32'(cfg_width) > MAX_WIDTH) begin
                        n_width = WIDTH_W'(MAX_WIDTH);
                    end else begin
                        n_width = WIDTH_W'(cfg_width);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Load/emit sequencing
    always_comb begin
        n_load_count = r_load_count;
        n_emitting   = r_emitting;
        n_column     = r_column;
        n_hrep       = r_hrep;
        n_vrep       = r_vrep;
        n_pad_count  = r_pad_count;
        o_ctl        = '0;
        load_inc     = r_load_count + WIDTH_W'(1);
        col_inc      = r_column + WIDTH_W'(1);
        hrep_inc     = {1'b0, r_hrep} + (REP_W+1)'(1);
        vrep_inc     = {1'b0, r_vrep} + (REP_W+1)'(1);
        pad_inc      = {1'b0, r_pad_count} + 3'd1;

        if (i_accept) begin
            if (i_operation == OP_LOAD) begin
                if (!r_emitting) begin
                    if (r_load_count < r_width) begin
                        o_ctl.wr_en   = 1'b1;
                        o_ctl.wr_addr = r_load_count[ADDR_W-1:0];
                        n_load_count  = load_inc;
                    end
                    if (n_load_count >= r_width) begin
                        n_emitting  = 1'b1;
                        n_column    = '0;
                        n_hrep      = '0;
                        n_vrep      = '0;
                        n_pad_count = '0;
                    end
                end
            end else if (r_emitting) begin
                o_ctl.res_valid = 1'b1;
                if (r_column < r_width) begin
                    o_ctl.kind    = KIND_PIXEL;
                    o_ctl.rd_en   = 1'b1;
                    o_ctl.rd_addr = r_column[ADDR_W-1:0];
                    if (32'(hrep_inc) >= 32'(r_scale)) begin
                        n_hrep   = '0;
                        n_column = col_inc;
                    end else begin
                        n_hrep = hrep_inc[REP_W-1:0];
                    end
                    o_ctl.row_end = (n_column >= r_width) && (pad == 2'd0);
                end else begin
                    o_ctl.kind    = KIND_PAD;
                    n_pad_count   = pad_inc[1:0];
                    o_ctl.row_end = pad_inc >= {1'b0, pad};
                end

                if (o_ctl.row_end) begin
                    n_column    = '0;
                    n_hrep      = '0;
                    n_pad_count = '0;
                    if (32'(vrep_inc) >= 32'(r_scale)) begin
                        o_ctl.pass_end = 1'b1;
                        n_vrep         = '0;
                        n_emitting     = 1'b0;
                        n_load_count   = '0;
                    end else begin
                        n_vrep = vrep_inc[REP_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale      <= SCALE_W'(1);
            r_width      <= WIDTH_W'(1);
            r_load_count <= '0;
            r_emitting   <= 1'b0;
            r_column     <= '0;
            r_hrep       <= '0;
            r_vrep       <= '0;
            r_pad_count  <= '0;
        end else begin
            r_scale      <= n_scale;
            r_width      <= n_width;
            r_load_count <= n_load_count;
            r_emitting   <= n_emitting;
            r_column     <= n_column;
            r_hrep       <= n_hrep;
            r_vrep       <= n_vrep;
            r_pad_count  <= n_pad_count;
        end
    end

endmodule

`default_nettype wire

// File: src/pixel_replicate_upscaler.sv
// pixel_replicate_upscaler: top level of the integer nearest-neighbor upscaler.
// Depends on prx_pkg, prx_seq and prx_ram.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel (i_valid / o_stall / i_data): each word is a load of one
//   source pixel (operation = OP_LOAD) or a pull of the next output word
//   (operation = OP_PULL). Loads fill the line buffer; once source_width
//   pixels are in, pulls return each pixel scale_factor times per row, then
//   the zero padding bytes that round the row to a multiple of four bytes,
//   and the whole row scale_factor times. Then loading starts again.
//   A pull while loading or a load while emitting is taken and dropped.
//   Output channel (o_valid / i_stall / o_data): one word per useful pull,
//   with row_end and pass_end tags.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 is
//   scale_factor, index 1 is source_width; write only while idle.
// Timing
//   One word accepted per clock while o_stall is low. A pull's result reaches
//   o_valid through the line buffer's registered read, held in the result
//   stage, and then through the output register.
//   When the receiver stalls, the result stage and the output register both
//   fill; o_stall rises only with both full, so nothing is lost.
// Reset
//   Synchronous, active low: loading phase, counters zero, scale 1, width 1.
//   The line buffer is not cleared and needs no clearing pass.

module pixel_replicate_upscaler
    import prx_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input words
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire t_in_word               i_data,
    // output words
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output t_out_word                   o_data,
    // configuration writes
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    typedef struct packed {
        logic kind;
        logic row_end;
        logic pass_end;
    } t_res_tag;

    t_seq_ctl           ctl;
    logic               in_acc;
    logic               s1_adv;
    logic [PIXEL_W-1:0] rd_pixel;

    // Result stage: tags wait here while the line buffer read completes
    logic     r_s1_valid;
    t_res_tag r_s1;

    // Output register
    logic      r_o_valid;
    t_out_word r_o;
    t_out_word n_o;

    assign o_cfg_ready = 1'b1;

    // The result stage drains whenever the output register is free or being taken
    assign s1_adv  = r_s1_valid && (!r_o_valid || !i_stall);
    assign o_stall = r_s1_valid && r_o_valid && i_stall;
    assign in_acc  = i_valid && !o_stall;

    prx_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_acc),
        .i_operation (i_data.operation),
        .o_ctl       (ctl)
    );

    // Line buffer: pixel stored as {red, green, blue}
    prx_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (ctl.wr_en),
        .i_wr_addr (ctl.wr_addr),
        .i_wr_data ({i_data.red, i_data.green, i_data.blue}),
        .i_rd_en   (ctl.rd_en),
        .i_rd_addr (ctl.rd_addr),
        .o_rd_data (rd_pixel)
    );

    // Padding words carry zero bytes; read data holds while the stage is stalled
    always_comb begin
        n_o.kind     = r_s1.kind;
        n_o.row_end  = r_s1.row_end;
        n_o.pass_end = r_s1.pass_end;
        if (r_s1.kind == KIND_PAD) begin
            n_o.out_blue  = 8'h00;
            n_o.out_green = 8'h00;
            n_o.out_red   = 8'h00;
        end else begin
            n_o.out_blue  = rd_pixel[7:0];
            n_o.out_green = rd_pixel[15:8];
            n_o.out_red   = rd_pixel[23:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= ctl.res_valid;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1.kind     <= ctl.kind;
            r_s1.row_end  <= ctl.row_end;
            r_s1.pass_end <= ctl.pass_end;
        end
        if (s1_adv) begin
            r_o <= n_o;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o;

    // A pass always closes on the last word of a row
    a_pass_is_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_data.pass_end || o_data.row_end))
        else $error("pass_end without row_end");

    // Padding words never carry pixel bytes
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.kind == KIND_PAD) |->
        (o_data.out_blue == 8'h00 && o_data.out_green == 8'h00 && o_data.out_red == 8'h00))
        else $error("padding word with nonzero bytes");

    // Backpressure only when both stages hold a result
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_o_valid))
        else $error("input stalled with a free stage");

    // Line buffer ports move only on an accepted word, never both at once
    a_ram_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.rd_en || ctl.wr_en) |-> (in_acc && !(ctl.rd_en && ctl.wr_en)))
        else $error("line buffer access without accepted word");

    // A stalled result stage keeps its read data: no read while it waits
    a_hold_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |-> !ctl.rd_en)
        else $error("line buffer read while result stage stalled");

endmodule

`default_nettype wire
